[hdl/pab_pkg.sv]
// ============================================================================
// pab_pkg: shared definitions for the power-of-two pool block allocator
// Sizes, field widths, command and status codes, and the control and status
// bundles between the controller and the datapath.
// ============================================================================
package pab_pkg;

    // Pool geometry
    localparam int NUM_POOLS       = 8;
    localparam int POOL_BYTES_LOG2 = 12;
    localparam int MIN_BLOCK_LOG2  = 3;
    localparam int POOL_SHIFT      = POOL_BYTES_LOG2 - MIN_BLOCK_LOG2;
    localparam int LINK_DEPTH      = NUM_POOLS << POOL_SHIFT;
    localparam int IDX_W           = $clog2(LINK_DEPTH);
    localparam int POOL_W          = $clog2(NUM_POOLS);
    localparam int LINK_W          = IDX_W + 1;
    localparam int MIN_SIZE        = 1 << MIN_BLOCK_LOG2;
    localparam int MAX_REQ         = 1 << (MIN_BLOCK_LOG2 + NUM_POOLS - 1);

    // Field widths
    localparam int CMD_W  = 2;
    localparam int REQ_W  = 16;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 10;

    // Stream widths
    localparam int S_TDATA_W = 32;
    localparam int S_PAD_W   = S_TDATA_W - REQ_W - IDX_W;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - IDX_W - POOL_W - 2 * CNT_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FAIL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DFREE = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;    // capture the accepted input transfer
        logic lookup;       // pick the pool and read the link memory
        logic sweep_start;  // reload pool registers, rewind the sweep
        logic sweep_step;   // write one link entry of the rebuild
        logic finish;       // commit state and load the result register
    } pab_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic sweep_last;   // current sweep entry is the final one
        logic item_init;    // captured item is a reinitialize command
    } pab_stat_t;

    // Number of blocks in pool p
    function automatic logic [CNT_W-1:0] pool_cap(input logic [POOL_W-1:0] p);
        int e;
        e = POOL_SHIFT - int'(p);
        if (e < 0) begin
            return '0;
        end
        return CNT_W'(32'd1 << e);
    endfunction

endpackage

[hdl/pab_ctrl.sv]
// ============================================================================
// pab_ctrl: allocator sequencer
// Steps each item through accept, lookup and commit, runs the list rebuild
// sweep after reset and on reinitialize, and owns the result valid flag.
// ============================================================================
module pab_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  pab_pkg::pab_stat_t  stat,
    output pab_pkg::pab_cmd_t   cmd
);

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_LOOKUP,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   init_pend_reg;   // sweep belongs to a reinitialize command
    logic   m_tvalid_reg;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // Command decode
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            S_SWEEP:  cmd.sweep_step = 1'b1;
            S_IDLE:   cmd.load_item  = s_tvalid;
            S_LOOKUP: begin
                cmd.sweep_start = stat.item_init;
                cmd.lookup      = !stat.item_init;
            end
            S_FINISH: cmd.finish = out_free;
            default:  cmd = '0;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_SWEEP;
            init_pend_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            // result valid: set on commit, cleared once the transfer is taken
            if (state_reg == S_FINISH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_SWEEP: begin
                    if (stat.sweep_last) begin
                        state_reg <= init_pend_reg ? S_FINISH : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_LOOKUP;
                    end
                end
                S_LOOKUP: begin
                    if (stat.item_init) begin
                        init_pend_reg <= 1'b1;
                        state_reg     <= S_SWEEP;
                    end else begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        init_pend_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[hdl/pab_datapath.sv]
// ============================================================================
// pab_datapath: allocator pool registers, link memory and result register
// Holds per-pool list heads and counts, the free-list link memory, the
// rebuild sweep counters, and forms each result.
// ============================================================================
module pab_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pab_pkg::pab_cmd_t                   cmd,
    output pab_pkg::pab_stat_t                  stat,
    input  logic [pab_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic [pab_pkg::CMD_W-1:0]           s_tuser,
    output logic [pab_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [pab_pkg::STAT_W-1:0]          m_tuser
);

    localparam int IDX_W   = pab_pkg::IDX_W;
    localparam int POOL_W  = pab_pkg::POOL_W;
    localparam int CNT_W   = pab_pkg::CNT_W;
    localparam int LINK_W  = pab_pkg::LINK_W;
    localparam int NP      = pab_pkg::NUM_POOLS;
    localparam int PS      = pab_pkg::POOL_SHIFT;
    localparam int M_PAD_W = pab_pkg::M_PAD_W;

    // Captured item
    logic [pab_pkg::CMD_W-1:0] cmd_reg;
    logic [pab_pkg::REQ_W-1:0] req_reg;
    logic [IDX_W-1:0]          fidx_reg;

    // Pool registers
    logic [IDX_W-1:0]  head_reg   [NP];
    logic              hvalid_reg [NP];
    logic [CNT_W-1:0]  count_reg  [NP];
    logic [CNT_W-1:0]  low_reg    [NP];

    // Lookup results
    logic [POOL_W-1:0] sel_reg;
    logic              hit_reg;
    logic              too_large_reg;
    logic [LINK_W-1:0] rdata_reg;

    // Sweep counters
    logic [POOL_W-1:0] sw_pool_reg;
    logic [PS-1:0]     sw_blk_reg;

    // Link memory
    logic [LINK_W-1:0] link_mem [pab_pkg::LINK_DEPTH];

    // Output registers
    logic [pab_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [pab_pkg::STAT_W-1:0]    m_tuser_reg;

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;
    assign stat.item_init = (cmd_reg == pab_pkg::CMD_INIT);

    // Item capture
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            cmd_reg  <= s_tuser;
            req_reg  <= s_tdata[pab_pkg::REQ_W-1:0];
            fidx_reg <= s_tdata[pab_pkg::REQ_W +: IDX_W];
        end
    end

    // Pool selection: size rounding then first nonempty pool upward
    logic [pab_pkg::REQ_W-1:0] req_eff;
    logic [POOL_W-1:0]         t0;
    logic [POOL_W-1:0]         sel;
    logic                      too_large;

    always_comb begin
        req_eff   = (32'(req_reg) < pab_pkg::MIN_SIZE) ?
                    pab_pkg::REQ_W'(pab_pkg::MIN_SIZE) : req_reg;
        too_large = 32'(req_eff) > pab_pkg::MAX_REQ;
        t0 = '0;
        for (int p = 0; p < NP - 1; p++) begin
            if ((32'd1 << (p + pab_pkg::MIN_BLOCK_LOG2)) < 32'(req_eff)) begin
                t0 = t0 + POOL_W'(1);
            end
        end
        sel = POOL_W'(NP - 1);
        for (int p = NP - 2; p >= 0; p--) begin
            if (POOL_W'(p) >= t0 && hvalid_reg[p]) begin
                sel = POOL_W'(p);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            sel_reg       <= sel;
            hit_reg       <= hvalid_reg[sel];
            too_large_reg <= too_large;
        end
    end

    // Sweep entry: block b of pool p sits at base + (b << p)
    logic [CNT_W-1:0]  sw_next_b;
    logic [CNT_W-1:0]  sw_cap;
    logic              sw_last_blk;
    logic [IDX_W-1:0]  sw_addr;
    logic [IDX_W-1:0]  sw_base;
    logic [LINK_W-1:0] sw_word;

    always_comb begin
        sw_cap      = pab_pkg::pool_cap(sw_pool_reg);
        sw_next_b   = CNT_W'(sw_blk_reg) + CNT_W'(1);
        sw_last_blk = (sw_next_b == sw_cap);
        sw_base     = IDX_W'({sw_pool_reg, PS'(0)});
        sw_addr     = IDX_W'({sw_pool_reg, PS'(sw_blk_reg << sw_pool_reg)});
        sw_word     = {sw_next_b < sw_cap,
                       sw_base + IDX_W'(CNT_W'(sw_next_b << sw_pool_reg))};
    end

    assign stat.sweep_last = sw_last_blk && (sw_pool_reg == POOL_W'(NP - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.sweep_start) begin
            sw_pool_reg <= '0;
            sw_blk_reg  <= '0;
        end else if (cmd.sweep_step) begin
            if (sw_last_blk) begin
                sw_blk_reg  <= '0;
                sw_pool_reg <= sw_pool_reg + POOL_W'(1);
            end else begin
                sw_blk_reg <= sw_blk_reg + PS'(1);
            end
        end
    end

    // Commit logic
    logic [POOL_W-1:0]         fp;
    logic [CNT_W:0]            fcount_inc;
    logic [CNT_W-1:0]          dec_cnt;
    logic                      upd_en;
    logic [POOL_W-1:0]         upd_pool;
    logic [IDX_W-1:0]          upd_head;
    logic                      upd_hvalid;
    logic [CNT_W-1:0]          upd_cnt;
    logic [CNT_W-1:0]          upd_low;
    logic                      free_we;
    logic [pab_pkg::STAT_W-1:0] o_stat;
    logic [IDX_W-1:0]          o_blk;
    logic [POOL_W-1:0]         o_pool;
    logic [CNT_W-1:0]          o_cnt;
    logic [CNT_W-1:0]          o_low;

    always_comb begin
        fp         = fidx_reg[IDX_W-1 -: POOL_W];
        fcount_inc = {1'b0, count_reg[fp]} + (CNT_W + 1)'(1);
        dec_cnt    = (count_reg[sel_reg] == '0) ? '0 : count_reg[sel_reg] - CNT_W'(1);
        upd_en     = 1'b0;
        upd_pool   = sel_reg;
        upd_head   = rdata_reg[IDX_W-1:0];
        upd_hvalid = rdata_reg[IDX_W];
        upd_cnt    = dec_cnt;
        upd_low    = (dec_cnt < low_reg[sel_reg]) ? dec_cnt : low_reg[sel_reg];
        free_we    = 1'b0;
        o_stat     = pab_pkg::STAT_OK;
        o_blk      = '0;
        o_pool     = '0;
        o_cnt      = '0;
        o_low      = '0;
        case (cmd_reg)
            pab_pkg::CMD_ALLOC: begin
                if (too_large_reg) begin
                    o_stat = pab_pkg::STAT_FAIL;
                end else if (!hit_reg) begin
                    o_stat = pab_pkg::STAT_FAIL;
                    o_pool = sel_reg;
                    o_cnt  = count_reg[sel_reg];
                    o_low  = low_reg[sel_reg];
                end else begin
                    upd_en = 1'b1;
                    o_blk  = head_reg[sel_reg];
                    o_pool = sel_reg;
                    o_cnt  = upd_cnt;
                    o_low  = upd_low;
                end
            end
            pab_pkg::CMD_FREE: begin
                o_pool = fp;
                // Every index decodes to a pool, so only the capacity check applies
                if (fcount_inc > {1'b0, pab_pkg::pool_cap(fp)}) begin
                    o_stat = pab_pkg::STAT_DFREE;
                    o_cnt  = count_reg[fp];
                    o_low  = low_reg[fp];
                end else begin
                    upd_en     = 1'b1;
                    free_we    = 1'b1;
                    upd_pool   = fp;
                    upd_head   = fidx_reg;
                    upd_hvalid = 1'b1;
                    upd_cnt    = fcount_inc[CNT_W-1:0];
                    upd_low    = low_reg[fp];
                    o_cnt      = upd_cnt;
                    o_low      = upd_low;
                end
            end
            pab_pkg::CMD_INIT: begin
                o_cnt = count_reg[0];
                o_low = low_reg[0];
            end
            default: begin
                o_stat = pab_pkg::STAT_OK;
            end
        endcase
    end

    // Pool registers: rebuilt on reset and reinitialize
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.sweep_start) begin
            for (int p = 0; p < NP; p++) begin
                head_reg[p]   <= IDX_W'({POOL_W'(p), PS'(0)});
                hvalid_reg[p] <= pab_pkg::pool_cap(POOL_W'(p)) != '0;
                count_reg[p]  <= pab_pkg::pool_cap(POOL_W'(p));
                low_reg[p]    <= pab_pkg::pool_cap(POOL_W'(p));
            end
        end else if (cmd.finish && upd_en) begin
            head_reg[upd_pool]   <= upd_head;
            hvalid_reg[upd_pool] <= upd_hvalid;
            count_reg[upd_pool]  <= upd_cnt;
            low_reg[upd_pool]    <= upd_low;
        end
    end

    // Link memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.sweep_step) begin
            link_mem[sw_addr] <= sw_word;
        end else if (cmd.finish && free_we) begin
            link_mem[fidx_reg] <= {hvalid_reg[fp], head_reg[fp]};
        end
        if (cmd.lookup) begin
            rdata_reg <= link_mem[head_reg[sel]];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_tuser_reg <= o_stat;
            m_tdata_reg <= {M_PAD_W'(0), o_low, o_cnt, o_pool, o_blk};
        end
    end

endmodule

[hdl/pow2_pool_block_allocator.sv]
// ============================================================================
// pow2_pool_block_allocator: power-of-two pool block allocator
// Segregated free lists over eight pools of 2^(p+3)-byte blocks with
// per-pool free counts and low-water marks.
// ============================================================================
// Each command transfer passes through accept, pool select with the
// link-memory read, and commit with the result register load; the
// link-memory read is registered ahead of the commit, the sequencer holds one
// item at a time, and a result that is not taken holds the commit. After reset
// and on every reinitialize command the free lists are rebuilt by a sweep that
// writes one link entry a cycle while s_tready stays low; a reinitialize
// result follows the sweep. Command codes travel in s_tuser, the status in
// m_tuser.
module pow2_pool_block_allocator (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Command stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pab_pkg::S_TDATA_W-1:0]     s_tdata,   // request_bytes, free_index
    input  logic [pab_pkg::CMD_W-1:0]         s_tuser,   // command
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pab_pkg::M_TDATA_W-1:0]     m_tdata,   // block_index, pool_used,
                                                         // free_blocks, min_free_blocks
    output logic [pab_pkg::STAT_W-1:0]        m_tuser    // status
);

    pab_pkg::pab_cmd_t  cmd;
    pab_pkg::pab_stat_t stat;

    pab_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pab_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // Result fields for checking
    localparam int IDX_W  = pab_pkg::IDX_W;
    localparam int POOL_W = pab_pkg::POOL_W;
    localparam int CNT_W  = pab_pkg::CNT_W;

    logic [POOL_W-1:0] out_pool;
    logic [CNT_W-1:0]  out_cnt;
    logic [CNT_W-1:0]  out_low;

    assign out_pool = m_tdata[IDX_W +: POOL_W];
    assign out_cnt  = m_tdata[IDX_W + POOL_W +: CNT_W];
    assign out_low  = m_tdata[IDX_W + POOL_W + CNT_W +: CNT_W];

    // One item in flight: an accepted transfer closes the input in the cycle after
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // Low-water mark never above the reported free count
    a_low_le_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_low <= out_cnt))
        else $error("low-water mark above free count");

    // Free count within the reported pool's capacity
    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_cnt <= pab_pkg::pool_cap(out_pool)))
        else $error("free count exceeds pool capacity");

    // Only defined status codes are produced
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == pab_pkg::STAT_OK || m_tuser == pab_pkg::STAT_FAIL ||
                      m_tuser == pab_pkg::STAT_DFREE))
        else $error("undefined status code");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for the power-of-two pool block allocator
// Drives allocate, free, reinitialize and reserved commands over the input
// stream and keeps a shadow copy of the free lists, free counts and low-water
// marks. Each result transfer is compared field by field with the oldest
// pending prediction. A short directed table comes first, then random
// traffic of mostly balanced allocate/free pairs with some misuse mixed in.
// ============================================================================
module tb;
    import pab_pkg::*;

    // Command code with no defined action
    localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;

    localparam int RANDOM_ITEMS = 450;
    localparam int IDLE_LIMIT   = 4096;  // well above the length of the init sweep
    localparam int DRAIN_CYCLES = 16;
    localparam int IDX_MASK     = LINK_DEPTH - 1;
    localparam logic [15:0] STALL_PATTERN = 16'b1101_1011_1001_0111;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  block_index;
        logic [POOL_W-1:0] pool_used;
        logic [CNT_W-1:0]  free_blocks;
        logic [CNT_W-1:0]  min_free_blocks;
    } alloc_result_t;

    // One directed transfer; fixed marks a result typed in by hand
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [REQ_W-1:0] req;
        logic [IDX_W-1:0] fidx;
        logic             fixed;
        alloc_result_t    res;
    } stim_row_t;

    localparam alloc_result_t NO_RES = '0;

    localparam stim_row_t DIRECTED [26] = '{
        // first allocate after reset, request under the minimum block
        {CMD_ALLOC, 16'd0,     12'd0,    1'b1, STAT_OK,    12'd0,    3'd0, 10'd511, 10'd511},
        {CMD_ALLOC, 16'd9,     12'd0,    1'b1, STAT_OK,    12'd512,  3'd1, 10'd255, 10'd255},
        // largest size that fits
        {CMD_ALLOC, 16'd1024,  12'd0,    1'b1, STAT_OK,    12'd3584, 3'd7, 10'd3,   10'd3},
        // too large
        {CMD_ALLOC, 16'd1025,  12'hFFF,  1'b1, STAT_FAIL,  12'd0,    3'd0, 10'd0,   10'd0},
        {CMD_ALLOC, 16'hFFFF,  12'd0,    1'b1, STAT_FAIL,  12'd0,    3'd0, 10'd0,   10'd0},
        // free back, then free beyond capacity
        {CMD_FREE,  16'hFFFF,  12'd3584, 1'b1, STAT_OK,    12'd0,    3'd7, 10'd4,   10'd3},
        {CMD_FREE,  16'd0,     12'd3584, 1'b1, STAT_DFREE, 12'd0,    3'd7, 10'd4,   10'd3},
        {CMD_FREE,  16'd0,     12'hFFF,  1'b0, NO_RES},
        {CMD_FREE,  16'd0,     12'd0,    1'b0, NO_RES},
        // not at a block start, still within capacity
        {CMD_FREE,  16'd0,     12'd513,  1'b0, NO_RES},
        // reserved command leaves everything alone
        {CMD_RSVD,  16'hFFFF,  12'hFFF,  1'b1, STAT_OK,    12'd0,    3'd0, 10'd0,   10'd0},
        {CMD_INIT,  16'd0,     12'd0,    1'b1, STAT_OK,    12'd0,    3'd0, 10'd512, 10'd512},
        // drain pool 6, then fall back to pool 7
        {CMD_ALLOC, 16'd500,   12'd0,    1'b0, NO_RES},
        {CMD_ALLOC, 16'd500,   12'd0,    1'b0, NO_RES},
        {CMD_ALLOC, 16'd500,   12'd0,    1'b0, NO_RES},
        {CMD_ALLOC, 16'd500,   12'd0,    1'b0, NO_RES},
        {CMD_ALLOC, 16'd500,   12'd0,    1'b0, NO_RES},
        {CMD_ALLOC, 16'd500,   12'd0,    1'b0, NO_RES},
        {CMD_ALLOC, 16'd500,   12'd0,    1'b0, NO_RES},
        {CMD_ALLOC, 16'd500,   12'd0,    1'b0, NO_RES},
        {CMD_ALLOC, 16'd500,   12'd0,    1'b0, NO_RES},
        // drain pool 7, then every candidate is empty
        {CMD_ALLOC, 16'd1024,  12'd0,    1'b0, NO_RES},
        {CMD_ALLOC, 16'd1024,  12'd0,    1'b0, NO_RES},
        {CMD_ALLOC, 16'd1024,  12'd0,    1'b0, NO_RES},
        {CMD_ALLOC, 16'd513,   12'd0,    1'b1, STAT_FAIL,  12'd0,    3'd7, 10'd0,   10'd0},
        {CMD_INIT,  16'd0,     12'd0,    1'b1, STAT_OK,    12'd0,    3'd0, 10'd512, 10'd512}
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]     s_tuser  = CMD_ALLOC;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]    m_tuser;

    // Shadow allocator state
    logic [IDX_W-1:0] link_next [LINK_DEPTH];
    logic             link_ok   [LINK_DEPTH];
    logic [IDX_W-1:0] head_idx  [NUM_POOLS];
    logic             head_ok   [NUM_POOLS];
    logic [CNT_W-1:0] free_cnt  [NUM_POOLS];
    logic [CNT_W-1:0] low_mark  [NUM_POOLS];

    alloc_result_t    pending_results [$];
    logic [IDX_W-1:0] held_blocks [$];
    int               mismatches  = 0;
    int               burst_left  = 0;
    int               idle_cycles = 0;
    logic [15:0]      rx_cycle    = '0;

    always #6 aclk = ~aclk;

    pow2_pool_block_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    function automatic int blocks_in_pool(input int p);
        if (p > POOL_SHIFT) begin
            return 0;
        end
        return 1 << (POOL_SHIFT - p);
    endfunction

    // Chain every block of each pool in address order
    function automatic void rebuild_free_lists();
        int cap;
        int base;
        int at;
        for (int i = 0; i < LINK_DEPTH; i++) begin
            link_next[i] = '0;
            link_ok[i]   = 1'b0;
        end
        for (int p = 0; p < NUM_POOLS; p++) begin
            cap         = blocks_in_pool(p);
            base        = p << POOL_SHIFT;
            free_cnt[p] = CNT_W'(cap);
            low_mark[p] = CNT_W'(cap);
            head_idx[p] = IDX_W'(base);
            head_ok[p]  = (cap != 0);
            for (int b = 0; b < cap; b++) begin
                at            = (base + (b << p)) & IDX_MASK;
                link_next[at] = IDX_W'((base + ((b + 1) << p)) & IDX_MASK);
                link_ok[at]   = (b + 1 < cap);
            end
        end
    endfunction

    // Update the shadow state for one command and return its result
    function automatic alloc_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                    input logic [REQ_W-1:0] req,
                                                    input logic [IDX_W-1:0] fidx);
        alloc_result_t r;
        int need;
        int p;
        logic [IDX_W-1:0] blk;
        r = '0;
        case (cmd)
            CMD_ALLOC: begin
                need = (int'(req) < MIN_SIZE) ? MIN_SIZE : int'(req);
                if (need > MAX_REQ) begin
                    r.status = STAT_FAIL;
                end else begin
                    // smallest fitting pool, then the first non-empty one above
                    p = 0;
                    while (p < NUM_POOLS - 1 && (1 << (p + MIN_BLOCK_LOG2)) < need) p++;
                    while (p < NUM_POOLS - 1 && !head_ok[p]) p++;
                    r.pool_used = POOL_W'(p);
                    if (!head_ok[p]) begin
                        r.status = STAT_FAIL;
                    end else begin
                        blk         = head_idx[p];
                        head_idx[p] = link_next[blk];
                        head_ok[p]  = link_ok[blk];
                        if (free_cnt[p] != 0) begin
                            free_cnt[p] = free_cnt[p] - 1'b1;
                        end
                        if (free_cnt[p] < low_mark[p]) begin
                            low_mark[p] = free_cnt[p];
                        end
                        r.status      = STAT_OK;
                        r.block_index = blk;
                    end
                    r.free_blocks     = free_cnt[p];
                    r.min_free_blocks = low_mark[p];
                end
            end
            CMD_FREE: begin
                p = int'(fidx) >> POOL_SHIFT;
                if (p >= NUM_POOLS) begin
                    r.status = STAT_DFREE;
                end else begin
                    r.pool_used = POOL_W'(p);
                    if (int'(free_cnt[p]) + 1 > blocks_in_pool(p)) begin
                        r.status = STAT_DFREE;
                    end else begin
                        // pushed as given, no check on the block itself
                        link_next[fidx] = head_idx[p];
                        link_ok[fidx]   = head_ok[p];
                        head_idx[p]     = fidx;
                        head_ok[p]      = 1'b1;
                        free_cnt[p]     = free_cnt[p] + 1'b1;
                        r.status        = STAT_OK;
                    end
                    r.free_blocks     = free_cnt[p];
                    r.min_free_blocks = low_mark[p];
                end
            end
            CMD_INIT: begin
                rebuild_free_lists();
                r.status          = STAT_OK;
                r.free_blocks     = free_cnt[0];
                r.min_free_blocks = low_mark[0];
            end
            default: begin
                // reserved: no state change, all fields zero
            end
        endcase
        return r;
    endfunction

    // Present one command and hold it until the transfer completes
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [REQ_W-1:0] req,
                             input logic [IDX_W-1:0] fidx, input logic fixed,
                             input alloc_result_t fixed_res, output alloc_result_t predicted);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_W'({fidx, req});
        do @(posedge aclk); while (!s_tready);
        predicted = apply_command(cmd, req, fidx);
        pending_results.push_back(fixed ? fixed_res : predicted);
    endtask

    // Sender bursts of random length with random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
        gap = $urandom_range(1, 6);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Stimulus
    initial begin : stimulus
        alloc_result_t    pred;
        logic [CMD_W-1:0] cmd;
        logic [REQ_W-1:0] req;
        logic [IDX_W-1:0] fidx;
        logic [IDX_W-1:0] last_freed;
        int               pick;
        int               p;
        int               k;
        last_freed = '0;
        rebuild_free_lists();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < $size(DIRECTED); i++) begin
            send_item(DIRECTED[i].cmd, DIRECTED[i].req, DIRECTED[i].fidx,
                      DIRECTED[i].fixed, DIRECTED[i].res, pred);
            pace_sender();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            req  = REQ_W'($urandom_range(0, 16'hFFFF));
            fidx = IDX_W'($urandom_range(0, IDX_MASK));
            if (pick < 48) begin
                // size spread over all pools, including sub-minimum sizes
                cmd = CMD_ALLOC;
                p   = $urandom_range(0, NUM_POOLS - 1);
                req = (p == 0) ? REQ_W'($urandom_range(0, MIN_SIZE))
                               : REQ_W'($urandom_range((1 << (p + 2)) + 1,
                                                       1 << (p + 3)));
            end else if (pick < 90) begin
                cmd = CMD_FREE;
                k   = $urandom_range(0, 7);
                if (k == 0) begin
                    fidx = last_freed;
                end else if (k == 1 || held_blocks.size() == 0) begin
                    // stray index, random within the whole link memory
                end else begin
                    k    = $urandom_range(0, held_blocks.size() - 1);
                    fidx = held_blocks[k];
                    held_blocks.delete(k);
                end
                last_freed = fidx;
            end else if (pick < 93) begin
                cmd = CMD_INIT;
            end else if (pick < 96) begin
                cmd = CMD_RSVD;
            end else begin
                cmd = CMD_ALLOC;
                req = REQ_W'($urandom_range(MAX_REQ + 1, 16'hFFFF));
            end

            send_item(cmd, req, fidx, 1'b0, NO_RES, pred);
            if (cmd == CMD_ALLOC && pred.status == STAT_OK) begin
                held_blocks.push_back(pred.block_index);
            end else if (cmd == CMD_INIT) begin
                held_blocks.delete();
            end
            pace_sender();
        end

        // Drain
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Result check and receiver stall pattern
    always @(posedge aclk) begin : result_check
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: status %0d, tdata %h", m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, m_tuser);
                check_field("block_index", want.block_index, m_tdata[0 +: IDX_W]);
                check_field("pool_used", want.pool_used, m_tdata[IDX_W +: POOL_W]);
                check_field("free_blocks", want.free_blocks,
                            m_tdata[IDX_W + POOL_W +: CNT_W]);
                check_field("min_free_blocks", want.min_free_blocks,
                            m_tdata[IDX_W + POOL_W + CNT_W +: CNT_W]);
            end
        end

        // always ready, fixed stall pattern, then random stalls
        rx_cycle <= rx_cycle + 1'b1;
        case (rx_cycle[9:8])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= STALL_PATTERN[rx_cycle[3:0]];
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
